// ===== src/fpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants of the camera step block
// Widths, CORDIC arctangent table, register indexes and the CORDIC
// request/response bundles.
// ----------------------------------------------------------------------------
package fpc_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int TURN_W       = 32;
	localparam int CW           = 33;
	localparam int VEC_W        = 16;
	localparam int POS_W        = 32;
	localparam int CUR_W        = 12;
	localparam int DIM_W        = 13;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int OFF_W        = 14;
	localparam int MUL_W        = 18;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int N_KEYS       = 6;
	localparam int S_DATA_W     = 32;
	localparam int M_DATA_W     = 3 * POS_W + 8 * VEC_W;

	localparam logic signed [CW-1:0]    TURN_Q30_GAIN = 33'sd652032874;
	localparam logic signed [VEC_W-1:0] Q14_ONE       = 16'sd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOK_GAIN,
		REG_MOVE_SPEED,
		REG_SCREEN_WIDTH,
		REG_SCREEN_HEIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic              start;
		logic [TURN_W-1:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [VEC_W-1:0] sin_v;
		logic signed [VEC_W-1:0] cos_v;
	} cordic_rsp_t;

	// arctangent of 2^-i as a 32-bit turn fraction
	function automatic logic [29:0] atan_turn(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10679838;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/first_person_camera_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_person_camera_step: mouselook and movement update of a camera
// Input transaction (s_*): cursor position and six movement keys. Output
// transaction (m_*): Q16.16 position and the forward, right and up vectors
// in Q1.14. Configuration: cfg_we/cfg_index/cfg_data write look gain, move
// speed, screen width and height; write them only while the block is idle.
// The block takes one transaction at a time. Its time is set by the one
// CORDIC unit, run once for yaw and once for pitch, and by the one 18x18
// multiplier that serves look deltas, vector products and the nine
// movement terms in turn. s_tready is high only between items.
// Reset clears yaw, pitch and position and loads the register defaults
// (gain 64, speed 256, 1024 x 768).
// A stalled receiver keeps the result in the output register; the block
// still accepts and computes the next item, then holds until that register
// is free.
// ----------------------------------------------------------------------------
module first_person_camera_step import fpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// cursor_x[11:0], cursor_y[23:12], key_forward[24], key_backward[25],
	// key_left[26], key_right[27], key_up[28], key_down[29], zero[31:30]
	input  logic [S_DATA_W-1:0]  s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64], fwd_x[111:96], fwd_y[127:112],
	// fwd_z[143:128], side_x[159:144], side_z[175:160], upv_x[191:176],
	// upv_y[207:192], upv_z[223:208]
	output logic [M_DATA_W-1:0]  m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK_X, S_LOOK_Y, S_PITCH,
		S_TRIG_Y, S_WAIT_Y, S_TRIG_P, S_WAIT_P,
		S_PMUL, S_PTAKE, S_MMUL, S_MRND, S_MADD, S_MSUB, S_OUT
	} state_t;

	localparam int KEY_FWD   = 0;
	localparam int KEY_BWD   = 1;
	localparam int KEY_LEFT  = 2;
	localparam int KEY_RIGHT = 3;
	localparam int KEY_UP    = 4;
	localparam int KEY_DOWN  = 5;

	localparam logic [1:0] VEC_FWD  = 2'd0;
	localparam logic [1:0] VEC_SIDE = 2'd1;
	localparam logic [1:0] VEC_UP   = 2'd2;

	localparam int N_COMP = 9;
	localparam int PSUM_W = PROD_W - 8;

	localparam logic signed [PSUM_W-1:0] PITCH_LIM = PSUM_W'(2 ** (ANGLE_BITS - 2));
	localparam logic signed [PSUM_W-1:0] PITCH_NEG = -PITCH_LIM;
	localparam logic signed [POS_W-1:0]  POS_MAX   = 32'sh7FFFFFFF;
	localparam logic signed [POS_W-1:0]  POS_MIN   = 32'sh80000000;

	state_t                       state_q;
	logic                         m_valid_q;
	logic [M_DATA_W-1:0]          m_data_q;
	logic [1:0]                   j_q, v_q, k_q;
	logic [3:0]                   m_q;

	logic [CFG_W-1:0]             look_gain_q, move_speed_q;
	logic [DIM_W-1:0]             screen_width_q, screen_height_q;

	logic [ANGLE_BITS-1:0]        yaw_q;
	logic signed [ANGLE_BITS-1:0] pitch_q;
	logic signed [POS_W-1:0]      pos_q [3];

	logic [CUR_W-1:0]             cur_x_q, cur_y_q;
	logic [N_KEYS-1:0]            keys_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [PROD_W-7:0]     d_q;
	logic signed [VEC_W-1:0]      sy_q, cy_q, sp_q, cp_q;
	logic signed [VEC_W-1:0]      vec_q [N_COMP];

	logic signed [OFF_W-1:0]      off_x, off_y;
	logic signed [MUL_W-1:0]      mul_a, mul_b;
	logic signed [PROD_W-1:0]     mul_p;
	logic signed [PROD_W-10:0]    dpitch;
	logic signed [PSUM_W-1:0]     p_sum;
	logic [ANGLE_BITS-1:0]        pitch_next;
	logic [PROD_W-1:0]            p14, rnd6;
	logic signed [VEC_W-1:0]      r14;
	logic signed [POS_W:0]        pos_ext, d_ext, mv_sum;
	logic signed [POS_W-1:0]      mv_sat;
	logic                         key_plus, key_minus;
	cordic_req_t                  cdc_req;
	cordic_rsp_t                  cdc_rsp;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_gain_q     <= 16'd64;
			move_speed_q    <= 16'd256;
			screen_width_q  <= 13'd1024;
			screen_height_q <= 13'd768;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOOK_GAIN:     look_gain_q     <= cfg_data;
				REG_MOVE_SPEED:    move_speed_q    <= cfg_data;
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[DIM_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign off_x = signed'({1'b0, screen_width_q}) - signed'({1'b0, cur_x_q, 1'b0});
	assign off_y = signed'({1'b0, screen_height_q}) - signed'({1'b0, cur_y_q, 1'b0});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_LOOK_X: begin
				mul_a = signed'({2'b00, look_gain_q});
				mul_b = MUL_W'(off_x);
			end
			S_LOOK_Y: begin
				mul_a = signed'({2'b00, look_gain_q});
				mul_b = MUL_W'(off_y);
			end
			S_PMUL: begin
				unique case (j_q)
					2'd0: begin mul_a = MUL_W'(cp_q); mul_b = MUL_W'(sy_q); end
					2'd1: begin mul_a = MUL_W'(cp_q); mul_b = MUL_W'(cy_q); end
					2'd2: begin mul_a = MUL_W'(sy_q); mul_b = MUL_W'(sp_q); end
					2'd3: begin mul_a = MUL_W'(cy_q); mul_b = MUL_W'(sp_q); end
					default: ;
				endcase
			end
			S_MMUL: begin
				mul_a = MUL_W'(vec_q[m_q]);
				mul_b = signed'({2'b00, move_speed_q});
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign dpitch = prod_q[PROD_W-1:9];
	assign p_sum  = PSUM_W'(pitch_q) + PSUM_W'(dpitch);

	always_comb begin
		priority if (p_sum > PITCH_LIM)
			pitch_next = PITCH_LIM[ANGLE_BITS-1:0];
		else if (p_sum < PITCH_NEG)
			pitch_next = PITCH_NEG[ANGLE_BITS-1:0];
		else
			pitch_next = p_sum[ANGLE_BITS-1:0];
	end

	assign p14  = prod_q + 36'sd8192;
	assign r14  = p14[29:14];
	assign rnd6 = prod_q + 36'sd32;

	assign pos_ext = (POS_W+1)'(pos_q[k_q]);
	assign d_ext   = (POS_W+1)'(d_q);
	assign mv_sum  = (state_q == S_MSUB) ? (pos_ext - d_ext) : (pos_ext + d_ext);

	always_comb begin
		priority if (mv_sum[POS_W] != mv_sum[POS_W-1])
			mv_sat = mv_sum[POS_W] ? POS_MIN : POS_MAX;
		else
			mv_sat = mv_sum[POS_W-1:0];
	end

	always_comb begin
		unique case (v_q)
			VEC_FWD: begin
				key_plus  = keys_q[KEY_FWD];
				key_minus = keys_q[KEY_BWD];
			end
			VEC_SIDE: begin
				key_plus  = keys_q[KEY_RIGHT];
				key_minus = keys_q[KEY_LEFT];
			end
			VEC_UP: begin
				key_plus  = keys_q[KEY_UP];
				key_minus = keys_q[KEY_DOWN];
			end
			default: begin
				key_plus  = 1'b0;
				key_minus = 1'b0;
			end
		endcase
	end

	always_comb begin
		cdc_req.start = (state_q == S_TRIG_Y) || (state_q == S_TRIG_P);
		cdc_req.angle = (state_q == S_TRIG_P)
			? {pitch_q, {(TURN_W - ANGLE_BITS){1'b0}}}
			: {yaw_q, {(TURN_W - ANGLE_BITS){1'b0}}};
	end

	fpc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cdc_req),
		.rsp    (cdc_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			j_q       <= '0;
			v_q       <= '0;
			k_q       <= '0;
			m_q       <= '0;
			yaw_q     <= '0;
			pitch_q   <= '0;
			pos_q[0]  <= '0;
			pos_q[1]  <= '0;
			pos_q[2]  <= '0;
		end else begin
			if (m_valid_q && m_tready && state_q != S_OUT)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (s_tvalid) state_q <= S_LOOK_X;
				S_LOOK_X: state_q <= S_LOOK_Y;
				S_LOOK_Y: begin
					yaw_q   <= yaw_q + prod_q[9 +: ANGLE_BITS];
					state_q <= S_PITCH;
				end
				S_PITCH: begin
					pitch_q <= pitch_next;
					state_q <= S_TRIG_Y;
				end
				S_TRIG_Y: state_q <= S_WAIT_Y;
				S_WAIT_Y: if (cdc_rsp.done) state_q <= S_TRIG_P;
				S_TRIG_P: state_q <= S_WAIT_P;
				S_WAIT_P: begin
					if (cdc_rsp.done) begin
						j_q     <= '0;
						state_q <= S_PMUL;
					end
				end
				S_PMUL: state_q <= S_PTAKE;
				S_PTAKE: begin
					if (j_q == 2'd3) begin
						v_q     <= VEC_FWD;
						k_q     <= '0;
						m_q     <= '0;
						state_q <= S_MMUL;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_PMUL;
					end
				end
				S_MMUL: state_q <= S_MRND;
				S_MRND: state_q <= S_MADD;
				S_MADD: begin
					if (key_plus)
						pos_q[k_q] <= mv_sat;
					state_q <= S_MSUB;
				end
				S_MSUB: begin
					if (key_minus)
						pos_q[k_q] <= mv_sat;
					if (m_q == 4'(N_COMP - 1)) begin
						state_q <= S_OUT;
					end else begin
						m_q <= m_q + 1'b1;
						if (k_q == 2'd2) begin
							k_q <= '0;
							v_q <= v_q + 1'b1;
						end else begin
							k_q <= k_q + 1'b1;
						end
						state_q <= S_MMUL;
					end
				end
				S_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {vec_q[8], vec_q[7], vec_q[6], vec_q[5], vec_q[3],
							vec_q[2], vec_q[1], vec_q[0], pos_q[2], pos_q[1], pos_q[0]};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (s_tvalid && s_tready) begin
			cur_x_q <= s_tdata[CUR_W-1:0];
			cur_y_q <= s_tdata[2*CUR_W-1:CUR_W];
			keys_q  <= s_tdata[2*CUR_W +: N_KEYS];
		end
		if (state_q == S_WAIT_Y && cdc_rsp.done) begin
			sy_q     <= cdc_rsp.sin_v;
			cy_q     <= cdc_rsp.cos_v;
			vec_q[3] <= -cdc_rsp.cos_v;
			vec_q[5] <= cdc_rsp.sin_v;
		end
		if (state_q == S_WAIT_P && cdc_rsp.done) begin
			sp_q     <= cdc_rsp.sin_v;
			cp_q     <= cdc_rsp.cos_v;
			vec_q[1] <= cdc_rsp.sin_v;
			vec_q[4] <= '0;
			vec_q[7] <= cdc_rsp.cos_v;
		end
		if (state_q == S_PTAKE) begin
			unique case (j_q)
				2'd0: vec_q[0] <= r14;
				2'd1: vec_q[2] <= r14;
				2'd2: vec_q[6] <= -r14;
				2'd3: vec_q[8] <= -r14;
				default: ;
			endcase
		end
		if (state_q == S_MRND)
			d_q <= rnd6[PROD_W-1:6];
	end

endmodule

// ===== src/fpc_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_cordic: iterative sine/cosine unit
// One rotation step per cycle on a 33-bit datapath, then rounding to Q1.14.
// ----------------------------------------------------------------------------
module fpc_cordic import fpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cordic_req_t req,
	output cordic_rsp_t rsp
);

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

	localparam logic signed [CW-1:0]    QUARTER_TURN = 33'sh040000000;
	localparam logic signed [CW-1:0]    HALF_TURN    = 33'sh080000000;
	localparam logic signed [CW-1:0]    RND_HALF     = 33'sd32768;
	localparam logic signed [CW-17:0]   TOP_ONE      = (CW-16)'(Q14_ONE);
	localparam logic signed [CW-17:0]   TOP_NEG_ONE  = -TOP_ONE;
	localparam logic signed [VEC_W-1:0] NEG_ONE      = -Q14_ONE;

	cstate_t                 state_q;
	logic                    done_q;
	logic                    neg_q;
	logic [STEP_W-1:0]       i_q;
	logic signed [CW-1:0]    x_q, y_q, z_q;
	logic signed [VEC_W-1:0] s_q, c_q;

	logic signed [CW-1:0]    a_in, a_red;
	logic                    red_neg;
	logic signed [CW-1:0]    x_sh, y_sh, atan_v;
	logic signed [CW-1:0]    x_rnd, y_rnd;
	logic signed [CW-17:0]   x_top, y_top;
	logic signed [VEC_W-1:0] x_sat, y_sat;

	always_comb begin
		a_in    = CW'(signed'(req.angle));
		a_red   = a_in;
		red_neg = 1'b0;
		priority if (a_in > QUARTER_TURN) begin
			a_red   = a_in - HALF_TURN;
			red_neg = 1'b1;
		end else if (a_in < -QUARTER_TURN) begin
			a_red   = a_in + HALF_TURN;
			red_neg = 1'b1;
		end else begin
			a_red   = a_in;
		end
	end

	assign x_sh   = x_q >>> i_q;
	assign y_sh   = y_q >>> i_q;
	assign atan_v = signed'({3'b000, atan_turn(5'(i_q))});

	assign x_rnd = x_q + RND_HALF;
	assign y_rnd = y_q + RND_HALF;
	assign x_top = x_rnd[CW-1:16];
	assign y_top = y_rnd[CW-1:16];

	always_comb begin
		priority if (x_top > TOP_ONE)
			x_sat = Q14_ONE;
		else if (x_top < TOP_NEG_ONE)
			x_sat = NEG_ONE;
		else
			x_sat = VEC_W'(x_top);
		priority if (y_top > TOP_ONE)
			y_sat = Q14_ONE;
		else if (y_top < TOP_NEG_ONE)
			y_sat = NEG_ONE;
		else
			y_sat = VEC_W'(y_top);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: if (req.start) state_q <= C_RUN;
				C_RUN:  if (i_q == STEP_W'(CORDIC_STEPS - 1)) state_q <= C_FIN;
				C_FIN: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (req.start) begin
					x_q   <= TURN_Q30_GAIN;
					y_q   <= '0;
					z_q   <= a_red;
					neg_q <= red_neg;
					i_q   <= '0;
				end
			end
			C_RUN: begin
				if (!z_q[CW-1]) begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + atan_v;
				end
				i_q <= i_q + 1'b1;
			end
			C_FIN: begin
				c_q <= x_sat;
				s_q <= y_sat;
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp.done  = done_q;
		rsp.sin_v = neg_q ? -s_q : s_q;
		rsp.cos_v = neg_q ? -c_q : c_q;
	end

endmodule

// ===== src/fpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_checker: port-level checks of the camera step block
// Output hold under stall and the one-item-at-a-time input behavior.
// ----------------------------------------------------------------------------
module fpc_checker import fpc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a transaction");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without an item in work");

endmodule

bind first_person_camera_step fpc_checker u_fpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
